/* rtl/core/e2g_pkg.sv */
// ============================================================================
// e2g_pkg: shared types, constants and table functions
// Fixed-point formats, WGS84 constants and elaboration-time CORDIC tables
// for the ECEF to geodetic converter.
// ============================================================================
`default_nettype none

package e2g_pkg;

    // datapath widths
    localparam int XW = 48;          // positions and ratios, signed
    localparam int AW = 50;          // internal angles, signed, pi = 2^AF
    localparam int AF = 47;
    localparam int MAX_STG = 48;
    localparam int CORDIC_STAGES_DEF = 32;

    // fixed-point constants
    localparam longint PI_I      = 64'sd1 << AF;
    localparam longint HALF_PI_I = 64'sd1 << (AF - 1);
    localparam longint ONE30     = 64'sd1 << 30;
    localparam longint A_MM      = 64'sd6378137000;
    localparam longint A_INT     = 64'sd1632803072000;
    localparam longint EA_INT    = 64'sd10930604213;
    localparam longint HB_INT    = 64'sd10967375747;
    localparam longint OMF_Q30   = 64'sd1070141771;
    localparam longint E2_Q30    = 64'sd7188036;
    localparam longint H_MAX     = 64'sd8589934591;
    localparam longint H_MIN     = -64'sd8589934592;

    // data handed from one CORDIC cell to the next
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] a;
        logic                 zero;
    } t_crd;

    // unsigned 64-bit quotient by shift and subtract, table building only
    function automatic longint e2g_udiv(input longint num, input longint den);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        int i;
        n = num;
        d = den;
        q = '0;
        r = '0;
        for (i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // atan(1/n) in Q60
    function automatic longint e2g_atan_inv(input longint n);
        longint term;
        longint sum;
        longint k;
        longint d;
        term = e2g_udiv(64'sd1 <<< 60, n);
        sum  = 0;
        k    = 0;
        while (term > 0) begin
            d = e2g_udiv(term, 2 * k + 1);
            if (k[0]) sum = sum - d;
            else      sum = sum + d;
            term = e2g_udiv(term, n * n);
            k = k + 1;
        end
        return sum;
    endfunction

    // atan(2^-i) in Q60
    function automatic longint e2g_atan_pow2(input int i);
        longint sum;
        longint d;
        int k;
        sum = 0;
        for (k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
            d = e2g_udiv(64'sd1 <<< (60 - i * (2 * k + 1)), 2 * k + 1);
            if (k[0]) sum = sum - d;
            else      sum = sum + d;
        end
        return sum;
    endfunction

    // floor(num * 2^bits / den)
    function automatic longint e2g_divq(input longint num, input longint den, input int bits);
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] rem;
        int i;
        d   = den;
        q   = e2g_udiv(num, den);
        rem = 64'(num) - q * d;
        for (i = 0; i < bits; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q   = q | 64'd1;
            end
        end
        return longint'(q);
    endfunction

    // micro-rotation angle of stage i, pi = 2^AF
    function automatic longint e2g_atan(input int i);
        longint pi60;
        pi60 = 16 * e2g_atan_inv(64'sd5) - 4 * e2g_atan_inv(64'sd239);
        if (i == 0) return 64'sd1 <<< (AF - 2);
        return e2g_divq(e2g_atan_pow2(i), pi60, AF);
    endfunction

    // reciprocal of the CORDIC gain in Q30, measured by vectoring (2^30, 0)
    function automatic longint e2g_invk(input int n);
        longint x;
        longint y;
        longint dx;
        longint dy;
        int i;
        x = ONE30;
        y = 0;
        for (i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
            end else begin
                x = x - dx;
                y = y + dy;
            end
        end
        if (x > 0) return e2g_udiv(64'sd1 <<< 60, x);
        return ONE30;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/e2g_delay.sv */
// ============================================================================
// e2g_delay: fixed-length register delay line
// Carries operands alongside the pipelined units so they meet their partners.
// ============================================================================
`default_nettype none

module e2g_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);

    generate
        if (D == 0) begin : g_none
            assign o_d = i_d;
        end else begin : g_line
            logic [W-1:0] r_sr [0:D-1];

            // shift line, one tap per cycle
            always_ff @(posedge i_clk) begin
                r_sr[0] <= i_d;
                for (int k = 1; k < D; k++) begin
                    r_sr[k] <= r_sr[k-1];
                end
            end

            assign o_d = r_sr[D-1];
        end
    endgenerate

endmodule

`default_nettype wire

/* rtl/core/e2g_mul30.sv */
// ============================================================================
// e2g_mul30: pipelined signed Q30 multiplier
// Returns (a * b) >> 30 truncated toward zero, from two registered partial
// products between registered magnitudes and a registered result.
// ============================================================================
`default_nettype none

module e2g_mul30 import e2g_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic signed [47:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed      [47:0] o_p
);

    logic        r_neg1;
    logic [47:0] r_m;
    logic [32:0] r_n;
    logic        r_neg2;
    logic [56:0] r_pl;
    logic [56:0] r_ph;
    logic [47:0] r_p;
    logic [80:0] w_sum;
    logic [47:0] w_mag;

    // sign and magnitudes
    always_ff @(posedge i_clk) begin
        r_neg1 <= i_a[47] ^ i_b[32];
        r_m    <= i_a[47] ? 48'(-i_a) : 48'(i_a);
        r_n    <= i_b[32] ? 33'(-i_b) : 33'(i_b);
    end

    // two partial products
    always_ff @(posedge i_clk) begin
        r_neg2 <= r_neg1;
        r_pl   <= {33'd0, r_m[23:0]} * {24'd0, r_n};
        r_ph   <= {33'd0, r_m[47:24]} * {24'd0, r_n};
    end

    // combine, scale and restore the sign
    assign w_sum = {r_ph, 24'd0} + 81'(r_pl);
    assign w_mag = w_sum[77:30];

    always_ff @(posedge i_clk) begin
        r_p <= r_neg2 ? 48'(-w_mag) : w_mag;
    end

    assign o_p = $signed(r_p);

endmodule

`default_nettype wire

/* rtl/core/e2g_cordic_cell.sv */
// ============================================================================
// e2g_cordic_cell: one CORDIC micro-rotation
// Registered step of a vectoring or rotating chain at a fixed shift.
// ============================================================================
`default_nettype none

module e2g_cordic_cell import e2g_pkg::*; #(
    parameter int IDX = 0,
    parameter bit VEC = 1'b1
) (
    input  wire logic i_clk,
    input  wire t_crd i_d,
    output t_crd      o_d
);

    localparam logic signed [AW-1:0] STEP = AW'(e2g_atan(IDX));

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic                 w_cw;
    t_crd                 n_d;
    t_crd                 r_d;

    // direction from the sign of y or of the residual angle
    always_comb begin
        w_dx = i_d.y >>> IDX;
        w_dy = i_d.x >>> IDX;
        w_cw = VEC ? (i_d.y >= 0) : (i_d.a < 0);
        n_d  = i_d;
        if (w_cw) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.a = i_d.a + STEP;
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.a = i_d.a - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

/* rtl/core/e2g_cordic.sv */
// ============================================================================
// e2g_cordic: CORDIC chain of cells
// Vectoring gives gained magnitude and angle; rotating gives cos and sin of
// the input angle from a start vector, after a registered entry stage.
// ============================================================================
`default_nettype none

module e2g_cordic import e2g_pkg::*; #(
    parameter int NSTG = CORDIC_STAGES_DEF,
    parameter bit VEC  = 1'b1
) (
    input  wire logic                 i_clk,
    input  wire logic signed [XW-1:0] i_x,
    input  wire logic signed [XW-1:0] i_y,
    input  wire logic signed [AW-1:0] i_ang,
    output logic signed      [XW-1:0] o_x,
    output logic signed      [XW-1:0] o_y,
    output logic signed      [AW-1:0] o_ang
);

    localparam logic signed [AW-1:0] PI_A = AW'(PI_I);

    t_crd r_pre;
    t_crd w_c [0:NSTG];

    // entry stage: in vectoring, fold the left half-plane and mark the zero vector
    always_ff @(posedge i_clk) begin
        if (VEC) begin
            r_pre.zero <= (i_x == 0) && (i_y == 0);
            if (i_x < 0) begin
                r_pre.x <= -i_x;
                r_pre.y <= -i_y;
                r_pre.a <= (i_y >= 0) ? PI_A : -PI_A;
            end else begin
                r_pre.x <= i_x;
                r_pre.y <= i_y;
                r_pre.a <= '0;
            end
        end else begin
            r_pre.zero <= 1'b0;
            r_pre.x    <= i_x;
            r_pre.y    <= i_y;
            r_pre.a    <= i_ang;
        end
    end

    assign w_c[0] = r_pre;

    // row of micro-rotation cells
    generate
        for (genvar g = 0; g < NSTG; g++) begin : g_cell
            e2g_cordic_cell #(
                .IDX (g),
                .VEC (VEC)
            ) u_cell (
                .i_clk (i_clk),
                .i_d   (w_c[g]),
                .o_d   (w_c[g+1])
            );
        end
    endgenerate

    assign o_x   = w_c[NSTG].x;
    assign o_y   = w_c[NSTG].y;
    assign o_ang = w_c[NSTG].zero ? '0 : w_c[NSTG].a;

endmodule

`default_nettype wire

/* rtl/core/e2g_div.sv */
// ============================================================================
// e2g_div: pipelined restoring divider
// floor(r * 2^30 / d) for 0 <= r < 2d, one quotient bit per stage.
// ============================================================================
`default_nettype none

module e2g_div import e2g_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [45:0] i_r,
    input  wire logic [45:0] i_d,
    output logic      [30:0] o_q
);

    localparam int NB = 30;

    logic [45:0] w_rem [0:NB];
    logic [45:0] w_den [0:NB];
    logic [30:0] w_q   [0:NB];
    logic [45:0] r_rem0;
    logic [45:0] r_den0;
    logic [30:0] r_q0;

    // integer part of the quotient
    always_ff @(posedge i_clk) begin
        r_den0 <= i_d;
        if (i_r >= i_d) begin
            r_rem0 <= i_r - i_d;
            r_q0   <= 31'd1;
        end else begin
            r_rem0 <= i_r;
            r_q0   <= 31'd0;
        end
    end

    assign w_rem[0] = r_rem0;
    assign w_den[0] = r_den0;
    assign w_q[0]   = r_q0;

    // one fraction bit per stage
    generate
        for (genvar g = 0; g < NB; g++) begin : g_step
            logic [45:0] w_sh;
            logic [45:0] r_rem;
            logic [45:0] r_den;
            logic [30:0] r_q;

            assign w_sh = w_rem[g] << 1;

            always_ff @(posedge i_clk) begin
                r_den <= w_den[g];
                if (w_sh >= w_den[g]) begin
                    r_rem <= w_sh - w_den[g];
                    r_q   <= {w_q[g][29:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {w_q[g][29:0], 1'b0};
                end
            end

            assign w_rem[g+1] = r_rem;
            assign w_den[g+1] = r_den;
            assign w_q[g+1]   = r_q;
        end
    endgenerate

    assign o_q = w_q[NB];

endmodule

`default_nettype wire

/* rtl/core/e2g_sqrt.sv */
// ============================================================================
// e2g_sqrt: pipelined bitwise integer square root
// floor(sqrt(w * 2^30)) for w <= 2^30, one result bit per stage.
// ============================================================================
`default_nettype none

module e2g_sqrt import e2g_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [30:0] i_w,
    output logic      [30:0] o_r
);

    localparam int NB = 32;

    logic [62:0] w_v [0:NB];
    logic [62:0] w_r [0:NB];

    assign w_v[0] = {2'b00, i_w, 30'd0};
    assign w_r[0] = '0;

    // one trial subtraction per stage, from the top bit pair down
    generate
        for (genvar g = 0; g < NB; g++) begin : g_step
            localparam logic [62:0] BIT = 63'd1 << (62 - 2 * g);
            logic [62:0] w_t;
            logic [62:0] r_v;
            logic [62:0] r_r;

            assign w_t = w_r[g] + BIT;

            always_ff @(posedge i_clk) begin
                if (w_v[g] >= w_t) begin
                    r_v <= w_v[g] - w_t;
                    r_r <= (w_r[g] >> 1) + BIT;
                end else begin
                    r_v <= w_v[g];
                    r_r <= w_r[g] >> 1;
                end
            end

            assign w_v[g+1] = r_v;
            assign w_r[g+1] = r_r;
        end
    endgenerate

    assign o_r = w_r[NB][30:0];

endmodule

`default_nettype wire

/* rtl/core/ecef_to_geodetic.sv */
// ============================================================================
// ecef_to_geodetic: WGS84 ECEF to geodetic conversion
// Bowring single-step latitude, atan2 longitude and ellipsoidal height from
// a signed millimetre position, fully pipelined.
// ============================================================================
// A new position is taken in every cycle (o_busy stays low) and each request
// gives exactly one result, strobed by o_valid for a single cycle. The
// datapath holds six CORDIC chains of CORDIC_STAGES + 1 register stages, a
// 31-stage divider, a 32-stage square root, ten multiplier slots and seven
// single-register steps. The receiver cannot stall the block, so results
// must be captured when o_valid is high. Angles are in units of pi/2^31
// radians; height is in whole millimetres, saturated to the 34-bit field.
// ============================================================================
`default_nettype none

module ecef_to_geodetic import e2g_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [33:0] i_pos_x,
    input  wire logic signed [33:0] i_pos_y,
    input  wire logic signed [33:0] i_pos_z,
    output logic                    o_valid,
    output logic signed      [31:0] o_latitude,
    output logic signed      [31:0] o_longitude,
    output logic signed      [33:0] o_height,
    output logic                    o_at_origin
);

    // pipeline timing, in cycles after the request
    localparam int LC  = CORDIC_STAGES + 1;
    localparam int LM  = 3;
    localparam int LD  = 31;
    localparam int LS  = 32;
    localparam int T0  = 1;
    localparam int T1  = T0 + LC;
    localparam int T2  = T1 + LM;
    localparam int T3  = T2 + LC;
    localparam int T4  = T3 + LM;
    localparam int T5  = T4 + LM;
    localparam int T6  = T5 + 1;
    localparam int T7  = T6 + LD;
    localparam int T8  = T7 + LM;
    localparam int T9  = T8 + LC;
    localparam int T10 = T9 + LC;
    localparam int T11 = T10 + LM;
    localparam int T12 = T11 + LM;
    localparam int T13 = T12 + LM;
    localparam int T14 = T13 + 1;
    localparam int T15 = T14 + LC;
    localparam int T16 = T15 + 1;
    localparam int T17 = T16 + LC;
    localparam int T18 = T17 + LM;
    localparam int T19 = T18 + LM;
    localparam int T20 = T19 + 1;
    localparam int T21 = T20 + LS;
    localparam int T22 = T21 + LM;
    localparam int T23 = T22 + 1;
    localparam int T24 = T23 + 1;

    localparam longint INVK = e2g_invk(CORDIC_STAGES);
    localparam logic signed [32:0]   INVK_B    = 33'(INVK);
    localparam logic signed [XW-1:0] INVK_X    = XW'(INVK);
    localparam logic signed [XW-1:0] OMF_A     = XW'(OMF_Q30);
    localparam logic signed [XW-1:0] EA_A      = XW'(EA_INT);
    localparam logic signed [XW-1:0] HB_A      = XW'(HB_INT);
    localparam logic signed [XW-1:0] E2_A      = XW'(E2_Q30);
    localparam logic signed [XW-1:0] AI_A      = XW'(A_INT);
    localparam logic signed [XW-1:0] ONE30_X   = XW'(ONE30);
    localparam logic signed [XW-1:0] H_MAX_X   = XW'(H_MAX);
    localparam logic signed [XW-1:0] H_MIN_X   = XW'(H_MIN);
    localparam logic signed [AW-1:0] HALF_PI_A = AW'(HALF_PI_I);
    localparam logic signed [AW-1:0] RND16     = AW'(32768);
    localparam logic signed [XW-1:0] RND8      = XW'(128);
    localparam logic        [33:0]   H_ORIGIN  = 34'(-A_MM);

    logic                 w_accept;
    logic [T24-1:0]       r_vld;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [XW-1:0] r_z;
    logic                 r_org;

    logic signed [XW-1:0] w_mag1;
    logic signed [AW-1:0] w_lon;
    logic signed [XW-1:0] w_p;
    logic signed [XW-1:0] w_z2;
    logic signed [XW-1:0] w_mag2;
    logic signed [XW-1:0] w_r;
    logic signed [XW-1:0] w_romf;
    logic signed [XW-1:0] w_r6;
    logic signed [XW-1:0] r_d;
    logic [30:0]          w_q;
    logic signed [XW-1:0] w_p7;
    logic signed [XW-1:0] w_pq;
    logic signed [XW-1:0] w_z8;
    logic signed [AW-1:0] w_t;
    logic signed [XW-1:0] w_ct;
    logic signed [XW-1:0] w_st;
    logic signed [XW-1:0] w_ct11;
    logic signed [XW-1:0] w_st11;
    logic signed [XW-1:0] w_ct2;
    logic signed [XW-1:0] w_st2;
    logic signed [XW-1:0] w_ct3;
    logic signed [XW-1:0] w_st3;
    logic signed [XW-1:0] w_hbs;
    logic signed [XW-1:0] w_eac;
    logic signed [XW-1:0] w_p13;
    logic signed [XW-1:0] w_z13;
    logic signed [XW-1:0] r_num;
    logic signed [XW-1:0] r_den;
    logic signed [AW-1:0] w_lat;
    logic signed [AW-1:0] r_lat;
    logic signed [XW-1:0] w_cl;
    logic signed [XW-1:0] w_sl;
    logic signed [XW-1:0] w_p17;
    logic signed [XW-1:0] w_z17;
    logic signed [XW-1:0] w_sl2;
    logic signed [XW-1:0] w_pcl;
    logic signed [XW-1:0] w_zsl;
    logic signed [XW-1:0] w_e;
    logic signed [XW-1:0] r_hs;
    logic signed [XW-1:0] w_wd;
    logic [30:0]          r_w;
    logic [30:0]          w_sq;
    logic signed [XW-1:0] w_asq;
    logic signed [XW-1:0] w_hs22;
    logic signed [XW-1:0] r_h;
    logic signed [AW-1:0] w_lon23;
    logic signed [AW-1:0] w_lat23;
    logic                 w_org23;
    logic signed [XW-1:0] w_hr;
    logic signed [AW-1:0] w_lat_r;
    logic signed [AW-1:0] w_lon_r;

    // request handshake and result strobe
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[T24-2:0], w_accept};
        end
    end

    assign o_valid = r_vld[T24-1];

    // input registers, millimetres with 8 fraction bits
    always_ff @(posedge i_clk) begin
        r_x   <= {{(XW-42){i_pos_x[33]}}, i_pos_x, 8'd0};
        r_y   <= {{(XW-42){i_pos_y[33]}}, i_pos_y, 8'd0};
        r_z   <= {{(XW-42){i_pos_z[33]}}, i_pos_z, 8'd0};
        r_org <= (i_pos_x == 0) && (i_pos_y == 0) && (i_pos_z == 0);
    end

    // longitude and equatorial distance
    e2g_cordic #(.NSTG(CORDIC_STAGES), .VEC(1'b1)) u_crd_lon (
        .i_clk (i_clk), .i_x (r_x), .i_y (r_y), .i_ang ('0),
        .o_x (w_mag1), .o_y (), .o_ang (w_lon)
    );

    e2g_mul30 u_mul_p (.i_clk (i_clk), .i_a (w_mag1), .i_b (INVK_B), .o_p (w_p));

    e2g_delay #(.W(XW), .D(T2 - T0)) u_dly_z2 (.i_clk (i_clk), .i_d (r_z), .o_d (w_z2));

    // geocentric distance
    e2g_cordic #(.NSTG(CORDIC_STAGES), .VEC(1'b1)) u_crd_rad (
        .i_clk (i_clk), .i_x (w_p), .i_y (w_z2), .i_ang ('0),
        .o_x (w_mag2), .o_y (), .o_ang ()
    );

    e2g_mul30 u_mul_r (.i_clk (i_clk), .i_a (w_mag2), .i_b (INVK_B), .o_p (w_r));

    // denominator r(1 - f) + e2 a
    e2g_mul30 u_mul_omf (.i_clk (i_clk), .i_a (w_r), .i_b (33'(OMF_A)), .o_p (w_romf));

    e2g_delay #(.W(XW), .D(T6 - T4)) u_dly_r6 (.i_clk (i_clk), .i_d (w_r), .o_d (w_r6));

    always_ff @(posedge i_clk) begin
        r_d <= w_romf + EA_A;
    end

    // ratio r / d in Q30
    e2g_div u_div (.i_clk (i_clk), .i_r (w_r6[45:0]), .i_d (r_d[45:0]), .o_q (w_q));

    e2g_delay #(.W(XW), .D(T7 - T2)) u_dly_p7 (.i_clk (i_clk), .i_d (w_p), .o_d (w_p7));

    e2g_mul30 u_mul_pq (
        .i_clk (i_clk), .i_a (w_p7), .i_b ({2'b00, w_q}), .o_p (w_pq)
    );

    e2g_delay #(.W(XW), .D(T8 - T2)) u_dly_z8 (.i_clk (i_clk), .i_d (w_z2), .o_d (w_z8));

    // auxiliary angle and its cosine and sine
    e2g_cordic #(.NSTG(CORDIC_STAGES), .VEC(1'b1)) u_crd_aux (
        .i_clk (i_clk), .i_x (w_pq), .i_y (w_z8), .i_ang ('0),
        .o_x (), .o_y (), .o_ang (w_t)
    );

    e2g_cordic #(.NSTG(CORDIC_STAGES), .VEC(1'b0)) u_rot_aux (
        .i_clk (i_clk), .i_x (INVK_X), .i_y ('0), .i_ang (w_t),
        .o_x (w_ct), .o_y (w_st), .o_ang ()
    );

    // cubes of cosine and sine
    e2g_mul30 u_mul_st2 (.i_clk (i_clk), .i_a (w_st), .i_b (w_st[32:0]), .o_p (w_st2));
    e2g_mul30 u_mul_ct2 (.i_clk (i_clk), .i_a (w_ct), .i_b (w_ct[32:0]), .o_p (w_ct2));

    e2g_delay #(.W(XW), .D(LM)) u_dly_st (.i_clk (i_clk), .i_d (w_st), .o_d (w_st11));
    e2g_delay #(.W(XW), .D(LM)) u_dly_ct (.i_clk (i_clk), .i_d (w_ct), .o_d (w_ct11));

    e2g_mul30 u_mul_st3 (
        .i_clk (i_clk), .i_a (w_st2), .i_b (w_st11[32:0]), .o_p (w_st3)
    );
    e2g_mul30 u_mul_ct3 (
        .i_clk (i_clk), .i_a (w_ct2), .i_b (w_ct11[32:0]), .o_p (w_ct3)
    );

    e2g_mul30 u_mul_hb (.i_clk (i_clk), .i_a (HB_A), .i_b (w_st3[32:0]), .o_p (w_hbs));
    e2g_mul30 u_mul_ea (.i_clk (i_clk), .i_a (EA_A), .i_b (w_ct3[32:0]), .o_p (w_eac));

    e2g_delay #(.W(XW), .D(T13 - T7)) u_dly_p13 (.i_clk (i_clk), .i_d (w_p7), .o_d (w_p13));
    e2g_delay #(.W(XW), .D(T13 - T8)) u_dly_z13 (.i_clk (i_clk), .i_d (w_z8), .o_d (w_z13));

    // Bowring numerator and denominator
    always_ff @(posedge i_clk) begin
        r_num <= w_z13 + w_hbs;
        r_den <= w_p13 - w_eac;
    end

    e2g_cordic #(.NSTG(CORDIC_STAGES), .VEC(1'b1)) u_crd_lat (
        .i_clk (i_clk), .i_x (r_den), .i_y (r_num), .i_ang ('0),
        .o_x (), .o_y (), .o_ang (w_lat)
    );

    // latitude limited to the poles
    always_ff @(posedge i_clk) begin
        if (w_lat > HALF_PI_A) begin
            r_lat <= HALF_PI_A;
        end else if (w_lat < -HALF_PI_A) begin
            r_lat <= -HALF_PI_A;
        end else begin
            r_lat <= w_lat;
        end
    end

    e2g_cordic #(.NSTG(CORDIC_STAGES), .VEC(1'b0)) u_rot_lat (
        .i_clk (i_clk), .i_x (INVK_X), .i_y ('0), .i_ang (r_lat),
        .o_x (w_cl), .o_y (w_sl), .o_ang ()
    );

    e2g_delay #(.W(XW), .D(T17 - T13)) u_dly_p17 (.i_clk (i_clk), .i_d (w_p13), .o_d (w_p17));
    e2g_delay #(.W(XW), .D(T17 - T13)) u_dly_z17 (.i_clk (i_clk), .i_d (w_z13), .o_d (w_z17));

    // projections p cos(lat) + z sin(lat)
    e2g_mul30 u_mul_pcl (.i_clk (i_clk), .i_a (w_p17), .i_b (w_cl[32:0]), .o_p (w_pcl));
    e2g_mul30 u_mul_zsl (.i_clk (i_clk), .i_a (w_z17), .i_b (w_sl[32:0]), .o_p (w_zsl));

    // radius of curvature term 1 - e2 sin^2
    e2g_mul30 u_mul_sl2 (.i_clk (i_clk), .i_a (w_sl), .i_b (w_sl[32:0]), .o_p (w_sl2));
    e2g_mul30 u_mul_e (.i_clk (i_clk), .i_a (E2_A), .i_b (w_sl2[32:0]), .o_p (w_e));

    e2g_delay #(.W(XW), .D(T19 - T18)) u_dly_hsum (
        .i_clk (i_clk), .i_d (w_pcl + w_zsl), .o_d (r_hs)
    );

    assign w_wd = ONE30_X - w_e;

    always_ff @(posedge i_clk) begin
        r_w <= (w_wd < 0) ? 31'd0 : w_wd[30:0];
    end

    e2g_sqrt u_sqrt (.i_clk (i_clk), .i_w (r_w), .o_r (w_sq));

    e2g_mul30 u_mul_asq (
        .i_clk (i_clk), .i_a (AI_A), .i_b ({2'b00, w_sq}), .o_p (w_asq)
    );

    e2g_delay #(.W(XW), .D(T22 - T19)) u_dly_hs22 (.i_clk (i_clk), .i_d (r_hs), .o_d (w_hs22));

    // raw height, 8 fraction bits
    always_ff @(posedge i_clk) begin
        r_h <= w_hs22 - w_asq;
    end

    e2g_delay #(.W(AW), .D(T23 - T1)) u_dly_lon (.i_clk (i_clk), .i_d (w_lon), .o_d (w_lon23));
    e2g_delay #(.W(AW), .D(T23 - T16)) u_dly_lat (.i_clk (i_clk), .i_d (r_lat), .o_d (w_lat23));
    e2g_delay #(.W(1), .D(T23 - T0)) u_dly_org (.i_clk (i_clk), .i_d (r_org), .o_d (w_org23));

    // rounding and saturation
    assign w_hr    = (r_h + RND8) >>> 8;
    assign w_lat_r = ($signed(w_lat23) + RND16) >>> 16;
    assign w_lon_r = ($signed(w_lon23) + RND16) >>> 16;

    always_ff @(posedge i_clk) begin
        o_at_origin <= w_org23;
        if (w_org23) begin
            o_latitude  <= '0;
            o_longitude <= '0;
            o_height    <= $signed(H_ORIGIN);
        end else begin
            o_latitude  <= w_lat_r[31:0];
            o_longitude <= w_lon_r[31:0];
            if (w_hr > H_MAX_X) begin
                o_height <= H_MAX_X[33:0];
            end else if (w_hr < H_MIN_X) begin
                o_height <= H_MIN_X[33:0];
            end else begin
                o_height <= w_hr[33:0];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/e2g_checker.sv */
// ============================================================================
// e2g_checker: port-level checks for the converter
// Watches the result strobe and payload of the top level over time.
// ============================================================================
`default_nettype none

module e2g_checker import e2g_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic               o_busy,
    input wire logic               o_valid,
    input wire logic signed [31:0] o_latitude,
    input wire logic signed [31:0] o_longitude,
    input wire logic signed [33:0] o_height,
    input wire logic               o_at_origin
);

    localparam logic signed [31:0] LAT_LIM  = 32'sd1073741824;
    localparam logic signed [33:0] H_ORIGIN = 34'(-A_MM);

    // no result straight after a reset cycle
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

    // requests are never refused
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("request refused");

    // latitude lies between the poles
    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_latitude <= LAT_LIM) && (o_latitude >= -LAT_LIM))
        else $error("latitude beyond a pole");

    // earth centre gives the fixed answer
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_at_origin) |->
            (o_latitude == 0) && (o_longitude == 0) && (o_height == H_ORIGIN))
        else $error("wrong result for the earth centre");

endmodule

bind ecef_to_geodetic e2g_checker u_e2g_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .o_latitude  (o_latitude),
    .o_longitude (o_longitude),
    .o_height    (o_height),
    .o_at_origin (o_at_origin)
);

`default_nettype wire

/* test/tb_ecef_to_geodetic.sv */
// ============================================================================
// tb_ecef_to_geodetic: self-checking testbench for the ECEF to geodetic block
// Drives directed and random positions in bursts, predicts latitude,
// longitude, height and origin flag with a fixed-point CORDIC model and
// checks every strobed result in order against the expected queue.
// ============================================================================
`timescale 1ns / 1ps

// expected conversion results, oldest first
class geo_scoreboard;
    typedef struct {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [33:0] hgt;
        logic               org;
    } t_geo;

    t_geo   pending[$];
    int     errors;
    longint atan_tab[48];
    longint inv_gain;
    int     stages;

    function new(int n);
        longint pi60;
        longint kx;
        longint dummy;
        stages = n;
        errors = 0;
        pi60 = 16 * atan_recip(5) - 4 * atan_recip(239);
        atan_tab[0] = 64'sd1 <<< 45;
        for (int i = 1; i < 48; i++)
            atan_tab[i] = frac_div(atan_p2(i), pi60, 47);
        kx = vectoring(64'sd1 <<< 30, 0, dummy);
        inv_gain = (kx > 0) ? (64'sd1 <<< 60) / kx : (64'sd1 <<< 30);
    endfunction

    // atan(1/n) in Q60
    function longint atan_recip(longint n);
        longint term;
        longint acc;
        longint k;
        longint d;
        term = (64'sd1 <<< 60) / n;
        acc = 0;
        k = 0;
        while (term > 0) begin
            d = term / (2 * k + 1);
            acc = k[0] ? acc - d : acc + d;
            term = term / (n * n);
            k++;
        end
        return acc;
    endfunction

    // atan(2^-i) in Q60
    function longint atan_p2(int i);
        longint acc;
        longint d;
        acc = 0;
        for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
            d = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
            acc = (k % 2) ? acc - d : acc + d;
        end
        return acc;
    endfunction

    function longint frac_div(longint num, longint den, int bits);
        logic [63:0] dd;
        logic [63:0] q;
        logic [63:0] rm;
        dd = den;
        q = 64'(num) / dd;
        rm = 64'(num) % dd;
        for (int i = 0; i < bits; i++) begin
            rm = rm << 1;
            q = q << 1;
            if (rm >= dd) begin
                rm = rm - dd;
                q = q | 64'd1;
            end
        end
        return longint'(q);
    endfunction

    // product shifted down 30 bits, truncated toward zero
    function longint qmul(longint a, longint b);
        bit          neg;
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] r;
        neg = (a < 0) != (b < 0);
        m = (a < 0) ? -a : a;
        n = (b < 0) ? -b : b;
        r = (m >> 30) * n + (((m & 64'h3FFF_FFFF) * n) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint vectoring(longint x, longint y, output longint ang);
        longint a;
        longint dx;
        longint dy;
        a = 0;
        if (x == 0 && y == 0) begin
            ang = 0;
            return 0;
        end
        if (x < 0) begin
            a = (y >= 0) ? (64'sd1 <<< 47) : -(64'sd1 <<< 47);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; a += atan_tab[i];
            end else begin
                x -= dx; y += dy; a -= atan_tab[i];
            end
        end
        ang = a;
        return x;
    endfunction

    function void rotation(longint th, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = inv_gain;
        y = 0;
        for (int i = 0; i < stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (th >= 0) begin
                x -= dx; y += dy; th -= atan_tab[i];
            end else begin
                x += dx; y -= dy; th += atan_tab[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function longint int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // note an accepted request
    function void note_request(logic signed [33:0] px, logic signed [33:0] py,
                               logic signed [33:0] pz);
        t_geo   e;
        longint x, y, z, lon, lat, t, dmy, p, r, d, q, ct, st, cl, sl, w, h, num, den;
        x = px; y = py; z = pz;
        if (x == 0 && y == 0 && z == 0) begin
            e.lat = 0; e.lon = 0; e.hgt = -34'sd6378137000; e.org = 1'b1;
            pending.push_back(e);
            return;
        end
        x *= 256; y *= 256; z *= 256;
        p = qmul(vectoring(x, y, lon), inv_gain);
        r = qmul(vectoring(p, z, dmy), inv_gain);
        d = qmul(r, 64'sd1070141771) + 64'sd10930604213;
        q = frac_div(r, d, 30);
        dmy = vectoring(qmul(p, q), z, t);
        rotation(t, ct, st);
        num = z + qmul(64'sd10967375747, qmul(qmul(st, st), st));
        den = p - qmul(64'sd10930604213, qmul(qmul(ct, ct), ct));
        dmy = vectoring(den, num, lat);
        if (lat > (64'sd1 <<< 46)) lat = 64'sd1 <<< 46;
        if (lat < -(64'sd1 <<< 46)) lat = -(64'sd1 <<< 46);
        rotation(lat, cl, sl);
        w = (64'sd1 <<< 30) - qmul(64'sd7188036, qmul(sl, sl));
        if (w < 0) w = 0;
        h = qmul(p, cl) + qmul(z, sl)
            - qmul(64'sd1632803072000, int_sqrt(64'(w) << 30));
        h = (h + 128) >>> 8;
        if (h > 64'sd8589934591) h = 64'sd8589934591;
        if (h < -64'sd8589934592) h = -64'sd8589934592;
        e.lat = 32'((lat + (64'sd1 <<< 15)) >>> 16);
        e.lon = 32'((lon + (64'sd1 <<< 15)) >>> 16);
        e.hgt = 34'(h);
        e.org = 1'b0;
        pending.push_back(e);
    endfunction

    // compare a strobed result with the oldest expectation
    function void check_result(logic signed [31:0] lat, logic signed [31:0] lon,
                               logic signed [33:0] hgt, logic org);
        t_geo e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result lat %0d lon %0d h %0d", $time, lat, lon, hgt);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (lat !== e.lat) begin
            $display("%0t: latitude expected %0d actual %0d", $time, e.lat, lat);
            errors++;
        end
        if (lon !== e.lon) begin
            $display("%0t: longitude expected %0d actual %0d", $time, e.lon, lon);
            errors++;
        end
        if (hgt !== e.hgt) begin
            $display("%0t: height expected %0d actual %0d", $time, e.hgt, hgt);
            errors++;
        end
        if (org !== e.org) begin
            $display("%0t: origin flag expected %0b actual %0b", $time, e.org, org);
            errors++;
        end
    endfunction
endclass

module tb_ecef_to_geodetic;
    import e2g_pkg::*;

    localparam int LATENCY = 106 + 6 * CORDIC_STAGES_DEF;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [33:0] pos_x = '0;
    logic signed [33:0] pos_y = '0;
    logic signed [33:0] pos_z = '0;
    logic               busy;
    logic               valid;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [33:0] height;
    logic               at_origin;

    geo_scoreboard geo_sb = new(CORDIC_STAGES_DEF);

    ecef_to_geodetic uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .o_valid(valid), .o_latitude(latitude), .o_longitude(longitude),
        .o_height(height), .o_at_origin(at_origin)
    );

    always #5 clk = ~clk;

    // note requests and check results at the rising edge
    always @(posedge clk) begin
        if (rst_n && start && !busy) geo_sb.note_request(pos_x, pos_y, pos_z);
        if (rst_n && valid) geo_sb.check_result(latitude, longitude, height, at_origin);
    end

    // present one request and hold it until accepted
    task automatic send_position(logic signed [33:0] x, logic signed [33:0] y,
                                 logic signed [33:0] z);
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic go_idle(int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic signed [33:0] rand_coord(int kind);
        logic signed [33:0] v;
        case (kind)
            0: v = 34'({$urandom, $urandom});
            1: v = $signed(34'($urandom_range(12000000))) - 34'sd6000000;
            2: v = $signed(34'($urandom_range(6400000))) * 1000
                   + $signed(34'($urandom_range(2000000))) - 34'sd1000000;
            default: v = $signed(34'($urandom_range(2000))) - 34'sd1000;
        endcase
        if (kind == 2 && $urandom_range(1)) v = -v;
        return v;
    endfunction

    initial begin
        logic signed [33:0] mx;
        logic signed [33:0] mn;
        int burst;
        int kind;
        mx = 34'sh1_FFFF_FFFF;
        mn = -34'sh2_0000_0000;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: origin, poles, axes, field extremes, longitude at pi
        send_position(0, 0, 0);
        send_position(0, 0, 34'sd6356752314);
        send_position(0, 0, -34'sd6356752314);
        send_position(0, 0, 1);
        send_position(34'sd6378137000, 0, 0);
        send_position(-34'sd6378137000, 0, 0);
        send_position(-34'sd6378137000, -1, 0);
        send_position(0, 34'sd6378137000, 0);
        send_position(0, -34'sd6378137000, 0);
        send_position(mx, mx, mx);
        send_position(mn, mn, mn);
        send_position(mx, mn, 0);
        send_position(mn, mx, mx);
        send_position(1, 0, 0);
        send_position(-1, 0, 0);
        send_position(1000, 0, 1000);
        send_position(100000, 0, 1000000);
        send_position(34'sd3000000000, 34'sd3000000000, 34'sd4000000000);
        send_position(mn, 0, 0);
        send_position(mx, 0, mn);
        go_idle(0);

        // hold off until the pipeline drains
        while (geo_sb.pending.size() != 0) @(negedge clk);

        // random bursts with random gaps
        for (int n = 0; n < 1000; ) begin
            burst = $urandom_range(40, 1);
            for (int b = 0; b < burst && n < 1000; b++, n++) begin
                kind = $urandom_range(9);
                kind = (kind < 5) ? 2 : (kind < 7) ? 0 : (kind < 9) ? 1 : 3;
                send_position(rand_coord(kind), rand_coord(kind), rand_coord(kind));
            end
            go_idle($urandom_range(3) == 0 ? 0 : $urandom_range(20));
        end
        start <= 1'b0;

        while (geo_sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
        if (geo_sb.errors == 0) begin
            $display("** ecef_to_geodetic: PASSED **");
        end else begin
            $display("** ecef_to_geodetic: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("** ecef_to_geodetic: FAILED **");
        $finish;
    end
endmodule
